// ----- rtl/sorted_address_predecessor_search_defines.svh -----
// assertion macros used by the predecessor search rtl
`ifndef SORTED_ADDRESS_PREDECESSOR_SEARCH_DEFINES_SVH
`define SORTED_ADDRESS_PREDECESSOR_SEARCH_DEFINES_SVH

// check on every clock edge, masked while reset is asserted
`define SAPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define SAPS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/saps_pkg.sv -----
// shared types and constants for the sorted address predecessor search
package saps_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_WIDTH  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SUM_W       = CNT_W + 1;

  // register file
  localparam int CFG_AW = 3;
  localparam logic REG_ENTRY_COUNT  = 1'b0;
  localparam logic REG_OFFSET_LIMIT = 1'b1;
  localparam logic [31:0] OFFSET_LIMIT_RESET = 32'd100000;

  // item action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] entry_index;
    logic [31:0] entry_address;
    logic [31:0] query_pc;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [11:0] symbol_index;
    logic [31:0] offset;
  } out_item_t;

  typedef struct packed {
    logic [12:0] entry_count;
    logic [31:0] offset_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINAL
  } state_t;

endpackage

// ----- rtl/saps_ram.sv -----
// generic single write, single read ram with registered read data
module saps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/saps_cfg.sv -----
// apb register block: entry count and offset limit
module saps_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [saps_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output saps_pkg::cfg_t             cfg
);

  logic [12:0] entry_count_r;
  logic [31:0] offset_limit_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes, decoded on the word address bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r  <= '0;
      offset_limit_r <= saps_pkg::OFFSET_LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        saps_pkg::REG_ENTRY_COUNT:  entry_count_r  <= pwdata[12:0];
        saps_pkg::REG_OFFSET_LIMIT: offset_limit_r <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      saps_pkg::REG_ENTRY_COUNT:  prdata = 32'(entry_count_r);
      saps_pkg::REG_OFFSET_LIMIT: prdata = offset_limit_r;
      default:                    prdata = '0;
    endcase
  end

  assign cfg.entry_count  = entry_count_r;
  assign cfg.offset_limit = offset_limit_r;

endmodule

// ----- rtl/saps_search.sv -----
// table memory, binary search sequencer and result register
module saps_search (
  input  logic                clk,
  input  logic                rst_n,
  input  saps_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  saps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output saps_pkg::out_item_t out_data
);

  localparam int IDX_W = saps_pkg::IDX_W;
  localparam int CNT_W = saps_pkg::CNT_W;
  localparam int SUM_W = saps_pkg::SUM_W;
  localparam int AW    = saps_pkg::ADDR_WIDTH;

  saps_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [IDX_W-1:0]    mid_r, mid_nxt;
  logic [AW-1:0]       pc_r, pc_nxt;
  logic [AW-1:0]       cand_r, cand_nxt;
  logic                out_valid_r, out_valid_nxt;
  saps_pkg::out_item_t out_data_r, out_data_nxt;

  logic                in_fire;
  logic                out_free;
  logic [CNT_W-1:0]    count_clamp;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [AW-1:0]       ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [AW-1:0]       ram_rdata;
  logic                le;
  logic [CNT_W-1:0]    mid_p1;
  logic [SUM_W-1:0]    sum_a, sum_b;
  logic [IDX_W-1:0]    mid_a, mid_b;
  logic                cont_a, cont_b, cont;
  logic [AW-1:0]       pc_delta;
  logic                hit;

  // start address table
  saps_ram #(
    .WIDTH(AW),
    .DEPTH(saps_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // handshake
  assign in_ready  = (state_r == saps_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry count clamped to the table depth
  assign count_clamp = (32'(cfg.entry_count) > 32'(saps_pkg::TABLE_DEPTH)) ?
                       CNT_W'(saps_pkg::TABLE_DEPTH) : CNT_W'(cfg.entry_count);

  // both possible next probes, ready before the read data arrives
  assign le     = (ram_rdata <= pc_r);
  assign mid_p1 = CNT_W'(mid_r) + CNT_W'(1);
  assign sum_a  = SUM_W'(mid_p1) + SUM_W'(hi_r);
  assign sum_b  = SUM_W'(lo_r) + SUM_W'(mid_r);
  assign mid_a  = IDX_W'(sum_a >> 1);
  assign mid_b  = IDX_W'(sum_b >> 1);
  assign cont_a = (mid_p1 < hi_r);
  assign cont_b = (lo_r < CNT_W'(mid_r));
  assign cont   = le ? cont_a : cont_b;

  // distance to the candidate start and limit check
  assign pc_delta = pc_r - cand_r;
  assign hit      = (lo_r != '0) && (64'(pc_delta) <= 64'(cfg.offset_limit));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      saps_pkg::S_IDLE: begin
        if (in_fire && in_data.action == saps_pkg::ACT_QUERY) begin
          state_nxt = (count_clamp == '0) ? saps_pkg::S_FINAL : saps_pkg::S_PROBE;
        end
      end
      saps_pkg::S_PROBE: begin
        if (!cont) begin
          state_nxt = saps_pkg::S_FINAL;
        end
      end
      saps_pkg::S_FINAL: begin
        if (out_free) begin
          state_nxt = saps_pkg::S_IDLE;
        end
      end
      default: state_nxt = saps_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pc_nxt        = pc_r;
    cand_nxt      = cand_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = IDX_W'(in_data.entry_index);
    ram_wdata     = AW'(in_data.entry_address);
    ram_re        = 1'b0;
    ram_raddr     = mid_nxt;
    case (state_r)
      saps_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data.action == saps_pkg::ACT_LOAD) begin
            // slots past the table depth are dropped
            ram_we = (32'(in_data.entry_index) < 32'(saps_pkg::TABLE_DEPTH));
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_clamp;
            mid_nxt   = IDX_W'(count_clamp >> 1);
            pc_nxt    = AW'(in_data.query_pc);
            ram_re    = (count_clamp != '0);
            ram_raddr = mid_nxt;
          end
        end
      end
      saps_pkg::S_PROBE: begin
        if (le) begin
          lo_nxt   = mid_p1;
          cand_nxt = ram_rdata;
          mid_nxt  = mid_a;
        end else begin
          hi_nxt  = CNT_W'(mid_r);
          mid_nxt = mid_b;
        end
        ram_re    = cont;
        ram_raddr = mid_nxt;
      end
      saps_pkg::S_FINAL: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.found        = hit;
          out_data_nxt.symbol_index = hit ? 12'(lo_r - CNT_W'(1)) : '0;
          out_data_nxt.offset       = hit ? 32'(pc_delta) : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= saps_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search and result payload
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    pc_r       <= pc_nxt;
    cand_r     <= cand_nxt;
    out_data_r <= out_data_nxt;
  end

`include "sorted_address_predecessor_search_defines.svh"

  `SAPS_ASSERT_RST(a_probe_window, (state_r == saps_pkg::S_PROBE) |-> (lo_r < hi_r), "empty search window while probing")
  `SAPS_ASSERT_RST(a_mid_in_window, (state_r == saps_pkg::S_PROBE) |-> (CNT_W'(mid_r) >= lo_r && CNT_W'(mid_r) < hi_r), "probe index outside search window")
  `SAPS_ASSERT_RST(a_hi_bound, (state_r != saps_pkg::S_IDLE) |-> (hi_r <= CNT_W'(saps_pkg::TABLE_DEPTH)), "search bound past table depth")
  `SAPS_ASSERT_RST(a_query_starts, (in_fire && in_data.action == saps_pkg::ACT_QUERY) |=> (state_r != saps_pkg::S_IDLE), "query transaction did not start a search")
  `SAPS_ASSERT_CLK(a_reset_idle, !rst_n |=> (state_r == saps_pkg::S_IDLE && !out_valid_r), "sequencer not idle after reset")

endmodule

// ----- rtl/sorted_address_predecessor_search.sv -----
// load transaction: written to the table at the accept edge
// query transaction: an issue step reads the middle entry, each probe step compares one
// entry and reads the next, and a limit check step loads the result into the output
// register once it is free; one item is in flight at a time
// reset: registers to entry count 0, offset limit 100000, sequencer idle, output empty;
// table contents are undefined until loaded, no clearing pass
module sorted_address_predecessor_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  saps_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output saps_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [saps_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  saps_pkg::cfg_t cfg;

  // configuration registers
  saps_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // table and search engine
  saps_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the sorted address predecessor search block
`timescale 1ns / 1ps

module testbench;

  // table fill styles, settle time and phase length for the stimulus generator
  localparam int FILL_SORTED    = 0;
  localparam int FILL_DUPS      = 1;
  localparam int FILL_SCRAMBLED = 2;
  localparam int SETTLE_CYCLES  = 24;
  localparam int PHASE_ITEMS    = 55;

  typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  saps_pkg::in_item_t    in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  saps_pkg::out_item_t   out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [saps_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // stimulus side
  saps_pkg::in_item_t    queued_items[$];
  logic [31:0]           planned_starts[saps_pkg::TABLE_DEPTH];
  gap_mode_t             gap_mode = GAP_NONE;
  bit                    hold_go = 1'b0;
  logic                  rx_hold = 1'b0;

  // predictor state: table, registers and answers still owed
  logic [31:0]           symbol_starts[saps_pkg::TABLE_DEPTH];
  logic [12:0]           cur_entry_count = '0;
  logic [31:0]           cur_offset_limit = saps_pkg::OFFSET_LIMIT_RESET;
  saps_pkg::out_item_t   pending_answers[$];
  int unsigned           mismatches = 0;
  saps_pkg::out_item_t   want;

  sorted_address_predecessor_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // binary search for the last start at or below pc, limited by the offset register
  function automatic saps_pkg::out_item_t predecessor_of(logic [31:0] pc);
    int unsigned lo, hi, mid, span;
    logic [31:0] delta;
    saps_pkg::out_item_t ans;
    ans = '0;
    span = (cur_entry_count > saps_pkg::TABLE_DEPTH) ? saps_pkg::TABLE_DEPTH : cur_entry_count;
    lo = 0;
    hi = span;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (symbol_starts[mid] <= pc) lo = mid + 1;
      else hi = mid;
    end
    if (lo != 0) begin
      delta = pc - symbol_starts[lo - 1];
      if (delta <= cur_offset_limit) begin
        ans.found = 1'b1;
        ans.symbol_index = 12'(lo - 1);
        ans.offset = delta;
      end
    end
    return ans;
  endfunction

  function automatic bit roll(int unsigned pct);
    return ($urandom % 100) < pct;
  endfunction

  function automatic bit sender_gap();
    return (gap_mode == GAP_SENDER && roll(55)) || (gap_mode == GAP_BOTH && roll(8));
  endfunction

  function automatic bit receiver_stall();
    return (gap_mode == GAP_RECEIVER && roll(55)) || (gap_mode == GAP_BOTH && roll(8));
  endfunction

  // driver: present queued transactions, update the predictor on every accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.action == saps_pkg::ACT_LOAD)
          symbol_starts[in_data.entry_index] = in_data.entry_address;
        else
          pending_answers.push_back(predecessor_of(in_data.query_pc));
      end
      if (!in_valid || in_ready) begin
        if (queued_items.size() != 0 && !sender_gap()) begin
          in_valid <= 1'b1;
          in_data <= queued_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= !rx_hold && !receiver_stall();
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (1500) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d index=%0d offset=%h",
                   out_data.found, out_data.symbol_index, out_data.offset);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.found !== want.found || out_data.symbol_index !== want.symbol_index ||
            out_data.offset !== want.offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%0d index=%0d offset=%h, %s%0d %s%0d %s%h",
                     want.found, want.symbol_index, want.offset,
                     "got found=", out_data.found, "index=", out_data.symbol_index,
                     "offset=", out_data.offset);
        end
      end
    end
  end

  // apb write: setup cycle, access cycle, done when pready is seen
  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == saps_pkg::REG_ENTRY_COUNT) cur_entry_count = value[12:0];
    else cur_offset_limit = value;
  endtask

  task automatic push_load(logic [11:0] slot, logic [31:0] addr);
    saps_pkg::in_item_t it;
    it.action = saps_pkg::ACT_LOAD;
    it.entry_index = slot;
    it.entry_address = addr;
    it.query_pc = $urandom;
    planned_starts[slot] = addr;
    queued_items.push_back(it);
  endtask

  task automatic push_query(logic [31:0] pc);
    saps_pkg::in_item_t it;
    it.action = saps_pkg::ACT_QUERY;
    it.entry_index = 12'($urandom);
    it.entry_address = $urandom;
    it.query_pc = pc;
    queued_items.push_back(it);
  endtask

  // wait until every transaction is accepted and answered, then let the block settle
  task automatic drain();
    while (queued_items.size() != 0 || in_valid || pending_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // load slots 0..n-1 in the given style
  task automatic fill_table(int unsigned n, int style);
    logic [31:0] addr, step_max, step;
    int unsigned k;
    step_max = 32'hFFFF_FF00 / (n + 1);
    addr = roll(30) ? 32'h0 : $urandom_range(0, step_max);
    for (k = 0; k < n; k++) begin
      if (style == FILL_SCRAMBLED) addr = $urandom;
      push_load(12'(k), addr);
      step = (style == FILL_DUPS && roll(25)) ? 32'h0 : $urandom_range(1, step_max);
      addr = addr + step;
    end
  endtask

  // query address aimed at the entries, their edges and the limit boundary
  function automatic logic [31:0] pick_pc(int unsigned n_eff, logic [31:0] lim);
    logic [31:0] e;
    if (n_eff == 0) return roll(80) ? $urandom : (roll(50) ? 32'h0 : 32'hFFFF_FFFF);
    e = planned_starts[$urandom_range(0, n_eff - 1)];
    case ($urandom % 8)
      0:       return e;
      1, 2:    return e + $urandom_range(0, 255);
      3:       return e + lim;
      4:       return e + lim + 1;
      5:       return e - 1;
      6:       return $urandom;
      default: return roll(50) ? 32'h0 : 32'hFFFF_FFFF;
    endcase
  endfunction

  // stimulus sequencing
  initial begin
    int unsigned p, i, n_eff, count_val, r;
    logic [31:0] lim;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table straight out of reset
    push_query(32'h0);
    push_query(32'hFFFF_FFFF);
    drain();

    // one-entry table against the reset limit
    cfg_write(saps_pkg::REG_ENTRY_COUNT, 32'd1);
    push_load(12'd0, 32'h1000);
    push_query(32'h0FFF);
    push_query(32'h1000);
    push_query(32'h1000 + saps_pkg::OFFSET_LIMIT_RESET);
    push_query(32'h1000 + saps_pkg::OFFSET_LIMIT_RESET + 1);
    drain();

    // unsorted table, widest limit, extreme field values
    cfg_write(saps_pkg::REG_OFFSET_LIMIT, 32'hFFFF_FFFF);
    cfg_write(saps_pkg::REG_ENTRY_COUNT, 32'd4);
    push_load(12'd0, 32'h500);
    push_load(12'd1, 32'h100);
    push_load(12'd2, 32'h900);
    push_load(12'd3, 32'hFFFF_FFFF);
    push_load(12'd4095, 32'h0);
    push_query(32'h0);
    push_query(32'h600);
    push_query(32'h950);
    push_query(32'hFFFF_FFFF);
    drain();

    // random phases
    for (p = 0; p < 16; p++) begin
      gap_mode = gap_mode_t'(p % 4);
      case (p % 5)
        0:       lim = saps_pkg::OFFSET_LIMIT_RESET;
        1:       lim = 32'h0;
        2:       lim = 32'hFFFF_FFFF;
        3:       lim = $urandom_range(1, 4096);
        default: lim = $urandom;
      endcase
      if (p == 2) count_val = $urandom_range(100, 200);
      else if (p == 5) count_val = 0;
      else if (p == 9) count_val = $urandom_range(200, 400);
      else count_val = $urandom_range(1, 40);
      n_eff = (count_val > saps_pkg::TABLE_DEPTH) ? saps_pkg::TABLE_DEPTH : count_val;
      cfg_write(saps_pkg::REG_OFFSET_LIMIT, lim);
      cfg_write(saps_pkg::REG_ENTRY_COUNT, count_val);

      // load the table for this phase
      fill_table(n_eff, (p % 7 == 6) ? FILL_SCRAMBLED :
                        (p % 7 == 4) ? FILL_DUPS : FILL_SORTED);
      if (p == 6) begin
        gap_mode = GAP_NONE;
        hold_go = 1'b1;
      end

      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 7 && i == 25) drain();
        r = $urandom % 100;
        if (r < 10 && n_eff < saps_pkg::TABLE_DEPTH)
          push_load(12'($urandom_range(n_eff, saps_pkg::TABLE_DEPTH - 1)), $urandom);
        else if (r < 14 && n_eff > 0)
          push_load(12'($urandom_range(0, n_eff - 1)), $urandom);
        else
          push_query(pick_pc(n_eff, lim));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
